// ----- src/wal_pkg.sv -----
// ----------------------------------------------------------------------------
// wal_pkg: shared types and constants for the write-ahead log controller
// Field widths, event and result codes, config register indexes and the
// structs passed between the sequencer and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package wal_pkg;

  localparam int unsigned DEF_LOG_SLOTS = 30;

  localparam int unsigned BLK_W     = 32;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned KIND_W    = 4;
  localparam int unsigned PIN_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_AREA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_OP = 2'd2;

  // config reset values
  localparam logic [BLK_W-1:0] RST_LOG_START  = 32'd2;
  localparam logic [CNT_W-1:0] RST_LOG_AREA   = 5'd30;
  localparam logic [CNT_W-1:0] RST_MAX_PER_OP = 5'd10;

  typedef enum logic [MODE_W-1:0] {
    MODE_BEGIN   = 2'd0,
    MODE_END     = 2'd1,
    MODE_WRITE   = 2'd2,
    MODE_RECOVER = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANTED  = 4'd0,
    KIND_WAIT     = 4'd1,
    KIND_ENDED    = 4'd2,
    KIND_NEW      = 4'd3,
    KIND_ABSORBED = 4'd4,
    KIND_COPY     = 4'd5,
    KIND_HDR      = 4'd6,
    KIND_TOO_BIG  = 4'd7,
    KIND_OUTSIDE  = 4'd8,
    KIND_NO_OPEN  = 4'd9
  } kind_t;

  typedef enum logic [PIN_W-1:0] {
    PIN_NONE  = 2'd0,
    PIN_PIN   = 2'd1,
    PIN_UNPIN = 2'd2
  } pin_t;

  typedef struct packed {
    logic [BLK_W-1:0] log_start;
    logic [CNT_W-1:0] log_area;
    logic [CNT_W-1:0] max_per_op;
  } cfg_t;

  typedef struct packed {
    kind_t            kind;
    logic [BLK_W-1:0] src;
    logic [BLK_W-1:0] dst;
    logic [CNT_W-1:0] cnt;
    pin_t             pin;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// ----- src/wal_if.sv -----
// ----------------------------------------------------------------------------
// wal_if: valid/ready channels of the write-ahead log controller
// Event channel (in) and result channel (out), one word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wal_in_if;
  import wal_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BLK_W-1:0]  block_number;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, output mode, output block_number, output entry_count,
                  input ready);
  modport sink   (input valid, input mode, input block_number, input entry_count,
                  output ready);
endinterface

interface wal_out_if;
  import wal_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BLK_W-1:0]  source_block;
  logic [BLK_W-1:0]  dest_block;
  logic [CNT_W-1:0]  header_count;
  logic [PIN_W-1:0]  pin_change;
  logic              last;

  modport source (output valid, output kind, output source_block, output dest_block,
                  output header_count, output pin_change, output last, input ready);
  modport sink   (input valid, input kind, input source_block, input dest_block,
                  input header_count, input pin_change, input last, output ready);
endinterface

`default_nettype wire

// ----- src/write_ahead_log_controller_top.sv -----
// ----------------------------------------------------------------------------
// write_ahead_log_controller_top: redo-log transaction controller
// Admits operations, records logged blocks with absorption, runs group
// commit and recovery replay as a stream of result words.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake           Word
//  -------  ---  ------------------  ----------------------------------------
//  in_ch    in   valid/ready         mode, block_number, entry_count
//  out_ch   out  valid/ready         kind, source/dest block, count, pin, last
//  cfg_*    in   cfg_we (no stall)   cfg_index selects register, cfg_wdata
//
//  Begin, an end without commit and rejected writes: one word, loaded into
//  the output register once it is free. A block write walks the table
//  through the single RAM read port, one entry a cycle; an empty table takes
//  the block with no walk. Commit emits 2n + 2 words, one a cycle while the
//  output register is free; recovery entries are stored, replay is n + 1 words.
//  Reset is synchronous: counters and config registers return to defaults,
//  the block table is not cleared. A low out ready stalls only emitting states;
//  an event is taken only while the sequencer is idle, even if a word waits.
// ----------------------------------------------------------------------------
`default_nettype none

module write_ahead_log_controller_top #(
  parameter int unsigned LOG_SLOTS = wal_pkg::DEF_LOG_SLOTS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  wal_in_if.sink                            in_ch,
  wal_out_if.source                         out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [wal_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wal_pkg::CFG_W-1:0]     cfg_wdata
);
  import wal_pkg::*;

  cfg_t cfg_r;         // config registers
  logic out_valid_r;   // output word register
  res_t out_res_r;
  logic slot_free;     // output register empty or being drained
  logic res_load;
  res_t res;

  // config writes: unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.log_start  <= RST_LOG_START;
      cfg_r.log_area   <= RST_LOG_AREA;
      cfg_r.max_per_op <= RST_MAX_PER_OP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOG_START:  cfg_r.log_start  <= cfg_wdata;
        CFG_LOG_AREA:   cfg_r.log_area   <= cfg_wdata[CNT_W-1:0];
        CFG_MAX_PER_OP: cfg_r.max_per_op <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  wal_core #(.LOG_SLOTS(LOG_SLOTS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_mode   (in_ch.mode),
    .in_blk    (in_ch.block_number),
    .in_cnt    (in_ch.entry_count),
    .slot_free (slot_free),
    .res_load  (res_load),
    .res       (res)
  );

  // single output register parts the sequencer from the result sink
  assign slot_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_res_r.kind;
  assign out_ch.source_block = out_res_r.src;
  assign out_ch.dest_block   = out_res_r.dst;
  assign out_ch.header_count = out_res_r.cnt;
  assign out_ch.pin_change   = out_res_r.pin;
  assign out_ch.last         = out_res_r.last;

endmodule

`default_nettype wire

// ----- src/wal_ram.sv -----
// ----------------------------------------------------------------------------
// wal_ram: generic single-write, single-read RAM
// Registered read, write-first on an address clash; read data holds while
// no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module wal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 30,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/wal_core.sv -----
// ----------------------------------------------------------------------------
// wal_core: event sequencer for the write-ahead log controller
// Holds the op and table counters, walks the block table through one RAM
// read port and one comparator, and emits one result word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module wal_core #(
  parameter int unsigned LOG_SLOTS = wal_pkg::DEF_LOG_SLOTS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire wal_pkg::cfg_t             cfg,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [wal_pkg::MODE_W-1:0] in_mode,
  input  wire logic [wal_pkg::BLK_W-1:0]  in_blk,
  input  wire logic [wal_pkg::CNT_W-1:0]  in_cnt,
  input  wire logic                      slot_free,
  output logic                           res_load,
  output wal_pkg::res_t                  res
);
  import wal_pkg::*;

  localparam int unsigned IDX_W   = (LOG_SLOTS > 1) ? $clog2(LOG_SLOTS) : 1;
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(LOG_SLOTS);
  localparam int unsigned NEED_W  = 12;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EMIT = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_COPY = 5'b01000,
    ST_HDR  = 5'b10000
  } state_t;

  // which copy pass is running
  typedef enum logic [1:0] {
    PASS_LOG    = 2'd0,
    PASS_HOME   = 2'd1,
    PASS_REPLAY = 2'd2
  } pass_t;

  state_t           state_r, state_nxt;
  pass_t            pass_r, pass_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic [CNT_W-1:0] open_ops_r, open_ops_nxt;
  logic [CNT_W-1:0] logged_r, logged_nxt;
  logic [CNT_W-1:0] recv_r, recv_nxt;
  res_t             pend_r, pend_nxt;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [BLK_W-1:0] ram_wdata, ram_rdata;

  logic              accept;
  logic [CNT_W:0]    idx_inc;
  logic              idx_at_end_n, idx_at_end_log;
  logic [BLK_W-1:0]  slot_addr;
  logic [CNT_W:0]    ops_inc;
  logic [10:0]       admit_prod;
  logic [NEED_W-1:0] admit_need;
  logic              too_big;
  logic [CNT_W-1:0]  rec_n, recv_new;

  function automatic res_t mk_res(kind_t k, logic [BLK_W-1:0] s, logic [BLK_W-1:0] d,
                                  logic [CNT_W-1:0] c, pin_t p, logic l);
    res_t r;
    r.kind = k;
    r.src  = s;
    r.dst  = d;
    r.cnt  = c;
    r.pin  = p;
    r.last = l;
    return r;
  endfunction

  wal_ram #(.WIDTH(BLK_W), .DEPTH(LOG_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign idx_inc        = (CNT_W + 1)'(idx_r) + (CNT_W + 1)'(1);
  assign idx_at_end_n   = (idx_inc == {1'b0, n_r});
  assign idx_at_end_log = (idx_inc == {1'b0, logged_r});
  assign slot_addr      = cfg.log_start + BLK_W'(idx_r) + BLK_W'(1);

  // admission: logged + (open + 1) * max_per_op
  assign ops_inc    = {1'b0, open_ops_r} + (CNT_W + 1)'(1);
  assign admit_prod = 11'(ops_inc) * 11'(cfg.max_per_op);
  assign admit_need = NEED_W'(logged_r) + NEED_W'(admit_prod);

  // logged >= area - 1 (or >= LOG_SLOTS), done as logged + 1 >= area so small areas saturate
  assign too_big = (logged_r >= SLOTS_C) ||
                   (({1'b0, logged_r} + (CNT_W + 1)'(1)) >= {1'b0, cfg.log_area});

  assign rec_n    = (in_cnt > SLOTS_C) ? SLOTS_C : in_cnt;
  assign recv_new = (recv_r < rec_n) ? recv_r + CNT_W'(1) : recv_r;

  always_comb begin
    state_nxt    = state_r;
    pass_nxt     = pass_r;
    idx_nxt      = idx_r;
    n_nxt        = n_r;
    blk_nxt      = blk_r;
    open_ops_nxt = open_ops_r;
    logged_nxt   = logged_r;
    recv_nxt     = recv_r;
    pend_nxt     = pend_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = blk_r;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    res_load     = 1'b0;
    res          = mk_res(KIND_COPY, '0, '0, '0, PIN_NONE, 1'b0);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_t'(in_mode))
            MODE_BEGIN: begin
              state_nxt = ST_EMIT;
              if ((admit_need > NEED_W'(LOG_SLOTS)) || (open_ops_r == '1)) begin
                pend_nxt = mk_res(KIND_WAIT, '0, '0, logged_r, PIN_NONE, 1'b1);
              end else begin
                open_ops_nxt = open_ops_r + CNT_W'(1);
                pend_nxt     = mk_res(KIND_GRANTED, '0, '0, logged_r, PIN_NONE, 1'b1);
              end
            end
            MODE_END: begin
              if (open_ops_r == '0) begin
                state_nxt = ST_EMIT;
                pend_nxt  = mk_res(KIND_NO_OPEN, '0, '0, logged_r, PIN_NONE, 1'b1);
              end else begin
                open_ops_nxt = open_ops_r - CNT_W'(1);
                if ((open_ops_r == CNT_W'(1)) && (logged_r != '0)) begin
                  // group commit: first pass copies table entries into log slots
                  n_nxt     = logged_r;
                  pass_nxt  = PASS_LOG;
                  idx_nxt   = '0;
                  ram_re    = 1'b1;
                  state_nxt = ST_COPY;
                end else begin
                  state_nxt = ST_EMIT;
                  pend_nxt  = mk_res(KIND_ENDED, '0, '0, logged_r, PIN_NONE, 1'b1);
                end
              end
            end
            MODE_WRITE: begin
              if (too_big) begin
                state_nxt = ST_EMIT;
                pend_nxt  = mk_res(KIND_TOO_BIG, '0, '0, logged_r, PIN_NONE, 1'b1);
              end else if (open_ops_r == '0) begin
                state_nxt = ST_EMIT;
                pend_nxt  = mk_res(KIND_OUTSIDE, '0, '0, logged_r, PIN_NONE, 1'b1);
              end else if (logged_r == '0) begin
                ram_we     = 1'b1;
                ram_wdata  = in_blk;
                logged_nxt = CNT_W'(1);
                state_nxt  = ST_EMIT;
                pend_nxt   = mk_res(KIND_NEW, in_blk, '0, CNT_W'(1), PIN_PIN, 1'b1);
              end else begin
                blk_nxt   = in_blk;
                idx_nxt   = '0;
                ram_re    = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            MODE_RECOVER: begin
              if (recv_r < rec_n) begin
                ram_we    = 1'b1;
                ram_waddr = recv_r[IDX_W-1:0];
                ram_wdata = in_blk;
              end
              recv_nxt = recv_new;
              if (recv_new >= rec_n) begin
                n_nxt    = rec_n;
                pass_nxt = PASS_REPLAY;
                idx_nxt  = '0;
                if (rec_n == '0) begin
                  state_nxt = ST_HDR;
                end else begin
                  ram_re    = 1'b1;
                  state_nxt = ST_COPY;
                end
              end
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (ram_rdata == blk_r) begin
          state_nxt = ST_EMIT;
          pend_nxt  = mk_res(KIND_ABSORBED, blk_r, '0, logged_r, PIN_NONE, 1'b1);
        end else if (idx_at_end_log) begin
          ram_we     = 1'b1;
          ram_waddr  = logged_r[IDX_W-1:0];
          logged_nxt = logged_r + CNT_W'(1);
          state_nxt  = ST_EMIT;
          pend_nxt   = mk_res(KIND_NEW, blk_r, '0, logged_r + CNT_W'(1), PIN_PIN, 1'b1);
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_r + IDX_W'(1);
          idx_nxt   = idx_r + IDX_W'(1);
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          res_load  = 1'b1;
          res       = pend_r;
          state_nxt = ST_IDLE;
        end
      end

      ST_COPY: begin
        if (slot_free) begin
          res_load = 1'b1;
          unique case (pass_r)
            PASS_LOG:  res = mk_res(KIND_COPY, ram_rdata, slot_addr, '0, PIN_NONE, 1'b0);
            PASS_HOME: res = mk_res(KIND_COPY, slot_addr, ram_rdata, '0, PIN_UNPIN, 1'b0);
            default:   res = mk_res(KIND_COPY, slot_addr, ram_rdata, '0, PIN_NONE, 1'b0);
          endcase
          if (idx_at_end_n) begin
            state_nxt = ST_HDR;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r + IDX_W'(1);
            idx_nxt   = idx_r + IDX_W'(1);
          end
        end
      end

      ST_HDR: begin
        if (slot_free) begin
          res_load = 1'b1;
          if (pass_r == PASS_LOG) begin
            res       = mk_res(KIND_HDR, '0, cfg.log_start, n_r, PIN_NONE, 1'b0);
            pass_nxt  = PASS_HOME;
            idx_nxt   = '0;
            ram_re    = 1'b1;
            state_nxt = ST_COPY;
          end else begin
            res        = mk_res(KIND_HDR, '0, cfg.log_start, '0, PIN_NONE, 1'b1);
            logged_nxt = '0;
            if (pass_r == PASS_REPLAY) begin
              recv_nxt = '0;
            end
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pass_r     <= PASS_LOG;
      open_ops_r <= '0;
      logged_r   <= '0;
      recv_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      pass_r     <= pass_nxt;
      open_ops_r <= open_ops_nxt;
      logged_r   <= logged_nxt;
      recv_r     <= recv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    n_r    <= n_nxt;
    blk_r  <= blk_nxt;
    pend_r <= pend_nxt;
  end

endmodule

`default_nettype wire

// ----- src/wal_checker.sv -----
// ----------------------------------------------------------------------------
// wal_checker: port-level assertions for the write-ahead log controller
// Bound to the top level; watches the channel ports only.
// ----------------------------------------------------------------------------
`default_nettype none

module wal_port_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic [wal_pkg::MODE_W-1:0]    in_mode,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [wal_pkg::KIND_W-1:0]    out_kind,
  input wire logic [wal_pkg::BLK_W-1:0]     out_source_block,
  input wire logic [wal_pkg::BLK_W-1:0]     out_dest_block,
  input wire logic                         out_last
);
  import wal_pkg::*;

  // no word left standing after reset
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_source_block) && $stable(out_dest_block) && $stable(out_last))
    else $error("stalled output word changed");

  // mid-sequence word means the sequencer is still busy
  a_busy_mid_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("event accepted while a result sequence is open");

  // every event other than a recovery entry owes a result, so ready drops
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode != MODE_RECOVER) |=> !in_ready)
    else $error("ready held after an event that owes a result");

endmodule

bind write_ahead_log_controller_top wal_port_checker u_wal_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_mode          (in_ch.mode),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_source_block (out_ch.source_block),
  .out_dest_block   (out_ch.dest_block),
  .out_last         (out_ch.last)
);

`default_nettype wire
